// File: hdl/dls_pkg.sv
// Shared widths, register indexes and reset values of the discrete log search unit.
package dls_pkg;

  // Widths of the configuration registers and of the payload fields.
  localparam int unsigned CfgW    = 16;
  localparam int unsigned TargetW = 16;
  localparam int unsigned ExpW    = 16;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_BASE    = 1'b0,
    REG_MODULUS = 1'b1
  } cfg_idx_e;

  // Register reset values.
  localparam logic [CfgW-1:0] BaseReset    = 16'd2;
  localparam logic [CfgW-1:0] ModulusReset = 16'd30203;

endpackage

// File: hdl/discrete_log_search_unit.sv
// Discrete log search unit: solves base^x mod modulus = target by a block scan.
//
// A target is taken when start is high and busy is low. The unit first finds
// m = floor(sqrt(modulus)) one root bit per cycle (the root has half the used
// modulus width, rounded up), then reduces the base by the modulus, and then
// tests the exponents 0 .. m*m-1 in blocks of m. Each tested exponent takes a
// compare and then one modular multiplication in the shared shift-add-reduce
// unit, which handles one multiplier bit per cycle. A modulus below two or a
// target at or above the modulus gives a not-found result in the cycle after
// start. The result beat appears on found_o and exponent_o for exactly one
// cycle with done_o high; the receiver cannot stall it, so it must be captured
// in that cycle. Configuration must be written only while busy is low; the
// unit itself does not enforce this.
module discrete_log_search_unit #(
  parameter int unsigned MOD_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  dls_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [dls_pkg::CfgW-1:0]  cfg_wdata_i,
  input  logic                      start,
  input  logic [dls_pkg::TargetW-1:0] target_i,
  output logic                      busy,
  output logic                      done_o,
  output logic                      found_o,
  output logic [dls_pkg::ExpW-1:0]  exponent_o
);
  import dls_pkg::*;

  // Only the low bits of the modulus register up to its own width take part.
  localparam int unsigned MW    = (MOD_WIDTH < CfgW) ? MOD_WIDTH : CfgW;
  localparam int unsigned SW    = (MW + 1) / 2;
  localparam int unsigned CW    = 2 * SW;
  localparam int unsigned CntW  = $clog2(CfgW + 1);
  localparam int unsigned Shift = CfgW - MW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SQRT = 5'b00010,
    S_BRED = 5'b00100,
    S_SCAN = 5'b01000,
    S_MUL  = 5'b10000
  } state_e;

  // Configuration registers.
  logic [CfgW-1:0] base_q, modulus_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= BaseReset;
      modulus_q <= ModulusReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BASE:    base_q    <= cfg_wdata_i;
        REG_MODULUS: modulus_q <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  state_e             state_q, state_d;
  logic [TargetW-1:0] target_q, target_d;
  logic [MW-1:0]      mod_q, mod_d;
  logic [MW-1:0]      b_q, b_d;
  logic [SW-1:0]      m_q, m_d;
  logic [SW-1:0]      mask_q, mask_d;
  logic [MW-1:0]      rp_q, rp_d;
  logic [ExpW-1:0]    step_q, step_d;
  logic [SW-1:0]      j_q, j_d;
  logic [SW-1:0]      blk_q, blk_d;
  logic               hit_q, hit_d;
  logic [ExpW-1:0]    hit_exp_q, hit_exp_d;
  logic [MW-1:0]      acc_q, acc_d;
  logic [MW-1:0]      mcand_q, mcand_d;
  logic [CfgW-1:0]    mplier_q, mplier_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               done_q, done_d;
  logic               found_q, found_d;
  logic [ExpW-1:0]    exp_q, exp_d;

  // Shared unit: one step of interleaved modular multiplication.
  logic [MW+1:0] sum, mod1, mod2, red;
  logic [MW-1:0] acc_next;

  always_comb begin
    sum  = ({2'b00, acc_q} << 1) + (mplier_q[CfgW-1] ? {2'b00, mcand_q} : '0);
    mod1 = {2'b00, mod_q};
    mod2 = mod1 << 1;
    if (sum >= mod2) begin
      red = sum - mod2;
    end else if (sum >= mod1) begin
      red = sum - mod1;
    end else begin
      red = sum;
    end
    acc_next = red[MW-1:0];
  end

  // Root trial for the block size.
  logic [SW-1:0] trial;
  logic [CW-1:0] trial_sq;

  always_comb begin
    trial    = m_q | mask_q;
    trial_sq = CW'(trial) * CW'(trial);
  end

  // Scan compare.
  logic            mod_new_small, target_high;
  logic            hit_now, hit_any, last_j, last_blk;
  logic [ExpW-1:0] exp_any;
  logic [MW-1:0]   mod_new;

  always_comb begin
    mod_new       = modulus_q[MW-1:0];
    mod_new_small = (mod_new < MW'(2));
    target_high   = (target_i >= TargetW'(mod_new));
    hit_now       = (TargetW'(rp_q) == target_q);
    hit_any       = hit_q | hit_now;
    exp_any       = hit_now ? step_q : hit_exp_q;
    last_j        = (j_q == m_q - SW'(1));
    last_blk      = (blk_q == m_q - SW'(1));
  end

  // Next-state logic.
  always_comb begin
    state_d   = state_q;
    target_d  = target_q;
    mod_d     = mod_q;
    b_d       = b_q;
    m_d       = m_q;
    mask_d    = mask_q;
    rp_d      = rp_q;
    step_d    = step_q;
    j_d       = j_q;
    blk_d     = blk_q;
    hit_d     = hit_q;
    hit_exp_d = hit_exp_q;
    acc_d     = acc_q;
    mcand_d   = mcand_q;
    mplier_d  = mplier_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    found_d   = found_q;
    exp_d     = exp_q;

    unique case (state_q) inside
      S_IDLE: begin
        if (start) begin
          target_d = target_i;
          mod_d    = mod_new;
          m_d      = '0;
          mask_d   = SW'(1) << (SW - 1);
          if (mod_new_small || target_high) begin
            done_d  = 1'b1;
            found_d = 1'b0;
            exp_d   = '0;
          end else begin
            state_d = S_SQRT;
          end
        end
      end

      S_SQRT: begin
        if (trial_sq <= CW'(mod_q)) begin
          m_d = trial;
        end
        mask_d = mask_q >> 1;
        if (mask_q[0]) begin
          // Reduce the base as 1 * base through the shared unit.
          acc_d    = '0;
          mcand_d  = MW'(1);
          mplier_d = base_q;
          cnt_d    = CntW'(CfgW);
          state_d  = S_BRED;
        end
      end

      S_BRED, S_MUL: begin
        acc_d    = acc_next;
        mplier_d = mplier_q << 1;
        cnt_d    = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          state_d = S_SCAN;
          if (state_q == S_BRED) begin
            b_d    = acc_next;
            rp_d   = MW'(1);
            step_d = '0;
            j_d    = '0;
            blk_d  = '0;
            hit_d  = 1'b0;
          end else begin
            rp_d = acc_next;
          end
        end
      end

      S_SCAN: begin
        if (last_j && hit_any) begin
          done_d  = 1'b1;
          found_d = 1'b1;
          exp_d   = exp_any;
          state_d = S_IDLE;
        end else if (last_j && last_blk) begin
          done_d  = 1'b1;
          found_d = 1'b0;
          exp_d   = '0;
          state_d = S_IDLE;
        end else begin
          hit_d     = hit_any;
          hit_exp_d = exp_any;
          j_d       = last_j ? '0 : j_q + SW'(1);
          blk_d     = last_j ? blk_q + SW'(1) : blk_q;
          step_d    = step_q + ExpW'(1);
          acc_d     = '0;
          mcand_d   = b_q;
          mplier_d  = CfgW'(rp_q) << Shift;
          cnt_d     = CntW'(MW);
          state_d   = S_MUL;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      found_q <= 1'b0;
      exp_q   <= '0;
      cnt_q   <= '0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      found_q <= found_d;
      exp_q   <= exp_d;
      cnt_q   <= cnt_d;
      hit_q   <= hit_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    target_q  <= target_d;
    mod_q     <= mod_d;
    b_q       <= b_d;
    m_q       <= m_d;
    mask_q    <= mask_d;
    rp_q      <= rp_d;
    step_q    <= step_d;
    j_q       <= j_d;
    blk_q     <= blk_d;
    hit_exp_q <= hit_exp_d;
    acc_q     <= acc_d;
    mcand_q   <= mcand_d;
    mplier_q  <= mplier_d;
  end

  assign busy       = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign found_o    = found_q;
  assign exponent_o = exp_q;

endmodule

// File: hdl/dls_checker.sv
// Port-level checker for the discrete log search unit, bound to the top level.
module dls_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        done_o,
  input logic                        found_o,
  input logic [dls_pkg::ExpW-1:0]    exponent_o
);
  import dls_pkg::*;

  // A not-found beat carries a zero exponent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (exponent_o == '0))
    else $error("not-found result with nonzero exponent");

  // An accepted target either finishes at once or keeps the unit busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted target neither busy nor done");

  // A result beat is only shown once the unit is free again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while busy");

  // Leaving the busy phase always delivers a result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("search ended without a result beat");

  // The unit only becomes busy after a start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy without start");

endmodule

bind discrete_log_search_unit dls_checker u_dls_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .found_o    (found_o),
  .exponent_o (exponent_o)
);
